>>> src/btt_pkg.sv
// ---------------------------------------------------------------------------
// btt_pkg
// shared types and constants of the bucketed transposition table
// ---------------------------------------------------------------------------
`default_nettype none
package btt_pkg;
  localparam logic [1:0] OP_PROBE = 2'd0;
  localparam logic [1:0] OP_STORE = 2'd1;
  localparam logic [1:0] OP_EVAL  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;
  localparam logic [1:0] BOUND_EVAL  = 2'd0;
  localparam logic [1:0] BOUND_EXACT = 2'd3;
  localparam int SCORE_MAX = 32000;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] key;
    logic [7:0]  depth;
    logic signed [15:0] score;
    logic        score_present;
    logic signed [15:0] eval_score;
    logic        eval_present;
    logic [1:0]  bound_kind;
    logic [14:0] move_code;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  entry_bound;
    logic [7:0]  entry_depth;
    logic signed [15:0] entry_score;
    logic        entry_score_valid;
    logic signed [15:0] entry_eval;
    logic        entry_eval_valid;
    logic [14:0] entry_move;
    logic [9:0]  fill_permille;
  } rsp_t;

  // tag/meta word: valid, bound, depth, tag
  typedef struct packed {
    logic        valid;
    logic [1:0]  bound;
    logic [7:0]  depth;
    logic [15:0] tag;
  } meta_t;

  // payload word: score, score_ok, eval, eval_ok, move
  typedef struct packed {
    logic signed [15:0] score;
    logic        score_ok;
    logic signed [15:0] eval;
    logic        eval_ok;
    logic [14:0] move;
  } pay_t;

  function automatic logic signed [15:0] sat(input logic signed [15:0] v);
    logic signed [15:0] r;
    r = v;
    if (v > 16'sd32000) r = 16'sd32000;
    if (v < -16'sd32000) r = -16'sd32000;
    return r;
  endfunction

  // priority, offset by 1000 so it stays unsigned; 11 bits
  function automatic logic [10:0] prio(input meta_t m);
    logic [10:0] r;
    if (!m.valid) r = 11'd0;
    else if (m.bound == BOUND_EVAL) r = 11'd999;
    else r = 11'd1000 + {3'd0, m.depth} + ((m.bound == BOUND_EXACT) ? 11'd2 : 11'd0);
    return r;
  endfunction
endpackage
`default_nettype wire

>>> src/btt_if.sv
// ---------------------------------------------------------------------------
// btt_req_if / btt_rsp_if
// valid/ready channels of the transposition table
// ---------------------------------------------------------------------------
`default_nettype none
interface btt_req_if;
  logic valid;
  logic ready;
  btt_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface btt_rsp_if;
  logic valid;
  logic ready;
  btt_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/btt_front.sv
// ---------------------------------------------------------------------------
// btt_front
// accepts words and holds them in a two-entry queue for the back end
// ---------------------------------------------------------------------------
`default_nettype none
module btt_front (
  input  wire logic clk,
  input  wire logic rst,
  btt_req_if.sink   req,
  output btt_pkg::req_t q_data,
  output logic      q_valid,
  input  wire logic q_pop
);
  btt_pkg::req_t slot [2];
  logic rd;
  logic wr;
  logic [1:0] cnt;

  assign req.ready = !rst && (cnt != 2'd2);
  assign q_valid = (cnt != 2'd0);
  assign q_data = slot[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= 1'b0;
      wr <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (req.valid && req.ready) begin
        slot[wr] <= req.data;
        wr <= ~wr;
      end
      if (q_pop) rd <= ~rd;
      cnt <= cnt + {1'b0, req.valid && req.ready} - {1'b0, q_pop};
    end
  end
endmodule
`default_nettype wire

>>> src/btt_back.sv
// ---------------------------------------------------------------------------
// btt_back
// bucket read, way select and write back; clear sweep; response register
// ---------------------------------------------------------------------------
`default_nettype none
module btt_back #(
  parameter int BUCKETS = 4096,
  parameter int WAYS = 3
) (
  input  wire logic clk,
  input  wire logic rst,
  input  btt_pkg::req_t q_data,
  input  wire logic q_valid,
  output logic      q_pop,
  btt_rsp_if.source rsp
);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int TOTAL = BUCKETS * WAYS;
  localparam int CW = $clog2(TOTAL + 1);
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int MW = $bits(btt_pkg::meta_t);
  localparam int PW = $bits(btt_pkg::pay_t);
  localparam int XW = CW + 10;
  localparam int FS = XW + CW;
  localparam int RW = FS - $clog2(TOTAL) + 2;
  localparam logic [63:0] FRECIP = ((64'd1 << FS) + 64'(TOTAL) - 64'd1) / 64'(TOTAL);
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [WAYS*MW-1:0] meta_mem [BUCKETS];
  logic [WAYS*PW-1:0] pay_mem [BUCKETS];
  logic [WAYS*MW-1:0] meta_rd;
  logic [WAYS*PW-1:0] pay_rd;
  logic [1:0] state;
  logic [BW-1:0] sweep;
  logic [CW-1:0] occ;
  logic [CW-1:0] occ_next;
  btt_pkg::req_t cur;
  logic [BW-1:0] bidx;
  logic [15:0] tag;
  logic meta_we;
  logic pay_we;
  logic [WAYS*MW-1:0] meta_wd;
  logic [WAYS*PW-1:0] pay_wd;
  btt_pkg::rsp_t res;

  // occupied ways to permille by reciprocal multiplication
  function automatic logic [9:0] fill_of(input logic [CW-1:0] c);
    logic [XW-1:0] x;
    logic [XW+RW-1:0] y;
    x = XW'(c) * XW'(1000);
    y = (XW+RW)'(x) * (XW+RW)'(FRECIP[RW-1:0]);
    return 10'(y >> FS);
  endfunction

  assign bidx = BW'(cur.key % 64'(BUCKETS));
  assign tag = cur.key[63:48];
  assign q_pop = (state == S_IDLE) && q_valid && (!rsp.valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) meta_mem[sweep] <= '0;
    else if (meta_we) meta_mem[bidx] <= meta_wd;
    if (pay_we) pay_mem[bidx] <= pay_wd;
    meta_rd <= meta_mem[BW'(q_data.key % 64'(BUCKETS))];
    pay_rd <= pay_mem[BW'(q_data.key % 64'(BUCKETS))];
  end

  always_comb begin
    btt_pkg::meta_t m [WAYS];
    btt_pkg::pay_t p [WAYS];
    btt_pkg::meta_t tm;
    btt_pkg::pay_t tp;
    btt_pkg::meta_t nm;
    btt_pkg::pay_t np;
    logic found, has_empty, has_eo, same, doit;
    logic [WW-1:0] t, empty, eo, low_way;
    logic signed [15:0] sc, ev;
    logic [10:0] inc;
    logic [9:0] fill_now, fill_up;
    meta_wd = meta_rd;
    pay_wd = pay_rd;
    meta_we = 1'b0;
    pay_we = 1'b0;
    occ_next = occ;
    res = '0;
    tm = '0;
    tp = '0;
    nm = '0;
    np = '0;
    found = 1'b0; has_empty = 1'b0; has_eo = 1'b0;
    t = '0; empty = '0; eo = '0; low_way = '0;
    sc = btt_pkg::sat(cur.score);
    ev = btt_pkg::sat(cur.eval_score);
    inc = 11'd1000 + {3'd0, cur.depth} +
          ((cur.bound_kind == btt_pkg::BOUND_EXACT) ? 11'd2 : 11'd0);
    fill_now = fill_of(occ);
    fill_up = fill_of(occ + CW'(1));
    for (int w = 0; w < WAYS; w++) begin
      m[w] = meta_rd[w*MW +: MW];
      p[w] = pay_rd[w*PW +: PW];
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!found) begin
        if (m[w].valid && m[w].tag == tag) begin
          found = 1'b1; t = WW'(w);
        end else begin
          if (!m[w].valid && !has_empty) begin has_empty = 1'b1; empty = WW'(w); end
          if (m[w].valid && m[w].bound == btt_pkg::BOUND_EVAL && !has_eo) begin
            has_eo = 1'b1; eo = WW'(w);
          end
          if (btt_pkg::prio(m[w]) < btt_pkg::prio(m[low_way])) low_way = WW'(w);
        end
      end
    end
    same = found;
    doit = 1'b0;
    if (state == S_EXEC) begin
      unique case (cur.op)
        btt_pkg::OP_PROBE: begin
          if (found) begin
            res.hit = 1'b1;
            res.entry_bound = m[t].bound;
            res.entry_depth = m[t].depth;
            res.entry_score = p[t].score_ok ? p[t].score : '0;
            res.entry_score_valid = p[t].score_ok;
            res.entry_eval = p[t].eval_ok ? p[t].eval : '0;
            res.entry_eval_valid = p[t].eval_ok;
            res.entry_move = p[t].move;
          end
        end
        btt_pkg::OP_STORE: begin
          if (!same) t = has_empty ? empty : low_way;
          tm = m[t];
          tp = p[t];
          doit = 1'b1;
          if (!same && tm.valid && inc < btt_pkg::prio(tm)) doit = 1'b0;
          if (doit) begin
            if (!tm.valid) occ_next = occ + CW'(1);
            nm = tm;
            np = tp;
            if (same) begin
              if (cur.eval_present) begin np.eval = ev; np.eval_ok = 1'b1; end
              if (cur.move_code != '0 && np.move == '0) np.move = cur.move_code;
            end
            if (!(same && tp.score_ok && cur.depth < tm.depth)) begin
              nm.valid = 1'b1;
              nm.tag = tag;
              nm.depth = cur.depth;
              nm.bound = cur.bound_kind;
              np.score = cur.score_present ? sc : '0;
              np.score_ok = cur.score_present;
              if (!same) begin
                np.eval = cur.eval_present ? ev : '0;
                np.eval_ok = cur.eval_present;
              end
              if (!same || cur.move_code != '0) np.move = cur.move_code;
            end
            meta_we = 1'b1;
            pay_we = 1'b1;
            meta_wd[t*MW +: MW] = nm;
            pay_wd[t*PW +: PW] = np;
          end
        end
        btt_pkg::OP_EVAL: begin
          if (!same) t = has_empty ? empty : eo;
          if (same || has_empty || has_eo) begin
            tm = m[t];
            tp = p[t];
            nm = tm;
            np = tp;
            if (!tm.valid) occ_next = occ + CW'(1);
            if (!tm.valid || tm.tag != tag) begin
              nm.valid = 1'b1;
              nm.tag = tag;
              nm.depth = '0;
              nm.bound = btt_pkg::BOUND_EVAL;
              np.score = '0;
              np.score_ok = 1'b0;
              np.move = '0;
            end
            np.eval = ev;
            np.eval_ok = 1'b1;
            meta_we = 1'b1;
            pay_we = 1'b1;
            meta_wd[t*MW +: MW] = nm;
            pay_wd[t*PW +: PW] = np;
          end
        end
        default: occ_next = '0;
      endcase
    end
    if (occ_next == occ) res.fill_permille = fill_now;
    else if (occ_next == '0) res.fill_permille = '0;
    else res.fill_permille = fill_up;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sweep <= '0;
      occ <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          sweep <= sweep + BW'(1);
          if (sweep == BW'(BUCKETS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_pop) begin
            cur <= q_data;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          occ <= occ_next;
          rsp.data <= res;
          rsp.valid <= 1'b1;
          if (cur.op == btt_pkg::OP_CLEAR) begin
            sweep <= '0;
            state <= S_CLEAR;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> src/bucketed_transposition_table_top.sv
// ---------------------------------------------------------------------------
// bucketed_transposition_table_top
// three-way bucketed transposition table
// ---------------------------------------------------------------------------
// result path: the queued word is popped with the bucket read, then the update registers the result
// words: the back end finishes each bucket read-modify-write before it pops the next word
// clear: result after the update, then a sweep over all BUCKETS buckets before the next word
// reset: a sweep over all BUCKETS buckets after rst falls; the queue takes two words meanwhile
`default_nettype none
module bucketed_transposition_table_top #(
  parameter int BUCKETS = 4096,
  parameter int WAYS = 3
) (
  input wire logic clk,
  input wire logic rst,
  btt_req_if.sink   req,
  btt_rsp_if.source rsp
);
  btt_pkg::req_t q_data;
  logic q_valid;
  logic q_pop;

  btt_front u_front (
    .clk(clk), .rst(rst), .req(req),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
  );

  btt_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
    .clk(clk), .rst(rst), .q_data(q_data), .q_valid(q_valid),
    .q_pop(q_pop), .rsp(rsp)
  );

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.data.fill_permille <= 10'd1000)
    else $error("fill out of range");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.data.hit |-> rsp.data.entry_move == '0)
    else $error("miss carries data");
  a_pop_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
endmodule
`default_nettype wire

>>> test/bucketed_transposition_table_top_tb.sv
// ---------------------------------------------------------------------------
// bucketed_transposition_table_top_tb
// self-checking bench for the three-way bucketed transposition table: a
// directed table of words, then random bursts aimed at a few crowded buckets,
// with every result checked against a typed expectation or a cycle-free model of the bucket store
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module bucketed_transposition_table_top_tb;
  localparam int NBKT = 4096;
  localparam int NWAY = 3;
  localparam int RANDOM_WORDS = 650;
  localparam longint CYCLE_LIMIT = 600000;

  typedef struct {
    btt_pkg::req_t word;
    bit   typed;
    btt_pkg::rsp_t result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  btt_req_if req();
  btt_rsp_if rsp();

  bucketed_transposition_table_top dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  btt_pkg::meta_t tbl_meta [NBKT][NWAY];
  btt_pkg::pay_t  tbl_pay  [NBKT][NWAY];
  int    occupied;
  btt_pkg::rsp_t  pending_results [$];
  int    mismatches = 0;
  longint cycles = 0;
  stim_row_t rows [$];

  function automatic int way_rank(btt_pkg::meta_t m);
    if (!m.valid) return -1000;
    if (m.bound == btt_pkg::BOUND_EVAL) return -1;
    return int'(m.depth) + ((m.bound == btt_pkg::BOUND_EXACT) ? 2 : 0);
  endfunction

  function automatic logic signed [15:0] clamp_score(logic signed [15:0] v);
    if (v > 16'sd32000) return 16'sd32000;
    if (v < -16'sd32000) return -16'sd32000;
    return v;
  endfunction

  function automatic void table_clear();
    for (int b = 0; b < NBKT; b++)
      for (int w = 0; w < NWAY; w++) begin
        tbl_meta[b][w] = '0;
        tbl_pay[b][w] = '0;
      end
    occupied = 0;
  endfunction

  function automatic void table_store(btt_pkg::req_t r);
    int b;
    logic [15:0] tag;
    int t, empty, weakest;
    bit same, keep;
    logic signed [15:0] sc, ev;
    logic signed [15:0] old_eval;
    bit old_eval_ok;
    logic [14:0] old_move;
    b = int'(r.key[11:0]);
    tag = r.key[63:48];
    t = -1;
    empty = -1;
    weakest = 0;
    old_eval = '0;
    old_eval_ok = 1'b0;
    old_move = '0;
    sc = clamp_score(r.score);
    ev = clamp_score(r.eval_score);
    for (int w = 0; w < NWAY; w++) begin
      if (tbl_meta[b][w].valid && tbl_meta[b][w].tag == tag) begin
        t = w;
        break;
      end
      if (!tbl_meta[b][w].valid && empty < 0) empty = w;
      if (way_rank(tbl_meta[b][w]) < way_rank(tbl_meta[b][weakest])) weakest = w;
    end
    same = (t >= 0);
    if (!same) t = (empty >= 0) ? empty : weakest;
    if (!same && tbl_meta[b][t].valid) begin
      if (int'(r.depth) + ((r.bound_kind == btt_pkg::BOUND_EXACT) ? 2 : 0) <
          way_rank(tbl_meta[b][t])) return;
    end
    if (!tbl_meta[b][t].valid) occupied++;
    if (same) begin
      if (r.eval_present) begin
        tbl_pay[b][t].eval = ev;
        tbl_pay[b][t].eval_ok = 1'b1;
      end
      if (r.move_code != 0 && tbl_pay[b][t].move == 0) tbl_pay[b][t].move = r.move_code;
      keep = tbl_pay[b][t].score_ok && (r.depth < tbl_meta[b][t].depth);
      if (keep) return;
      old_eval = tbl_pay[b][t].eval;
      old_eval_ok = tbl_pay[b][t].eval_ok;
      old_move = tbl_pay[b][t].move;
    end
    tbl_meta[b][t].valid = 1'b1;
    tbl_meta[b][t].tag = tag;
    tbl_meta[b][t].depth = r.depth;
    tbl_meta[b][t].bound = r.bound_kind;
    tbl_pay[b][t].score = r.score_present ? sc : 16'sd0;
    tbl_pay[b][t].score_ok = r.score_present;
    tbl_pay[b][t].eval = r.eval_present ? ev : old_eval;
    tbl_pay[b][t].eval_ok = r.eval_present ? 1'b1 : old_eval_ok;
    tbl_pay[b][t].move = (r.move_code == 0 && same) ? old_move : r.move_code;
  endfunction

  function automatic void table_store_eval(btt_pkg::req_t r);
    int b;
    logic [15:0] tag;
    int t, empty, eonly;
    b = int'(r.key[11:0]);
    tag = r.key[63:48];
    t = -1;
    empty = -1;
    eonly = -1;
    for (int w = 0; w < NWAY; w++) begin
      if (tbl_meta[b][w].valid && tbl_meta[b][w].tag == tag) begin
        t = w;
        break;
      end
      if (!tbl_meta[b][w].valid) begin
        if (empty < 0) empty = w;
      end else if (tbl_meta[b][w].bound == btt_pkg::BOUND_EVAL && eonly < 0) begin
        eonly = w;
      end
    end
    if (t < 0) t = (empty >= 0) ? empty : eonly;
    if (t < 0) return;
    if (!tbl_meta[b][t].valid) occupied++;
    if (!tbl_meta[b][t].valid || tbl_meta[b][t].tag != tag) begin
      tbl_meta[b][t].valid = 1'b1;
      tbl_meta[b][t].tag = tag;
      tbl_meta[b][t].depth = '0;
      tbl_meta[b][t].bound = btt_pkg::BOUND_EVAL;
      tbl_pay[b][t].score = '0;
      tbl_pay[b][t].score_ok = 1'b0;
      tbl_pay[b][t].move = '0;
    end
    tbl_pay[b][t].eval = clamp_score(r.eval_score);
    tbl_pay[b][t].eval_ok = 1'b1;
  endfunction

  function automatic btt_pkg::rsp_t table_access(btt_pkg::req_t r);
    btt_pkg::rsp_t o;
    int b;
    o = '0;
    b = int'(r.key[11:0]);
    case (r.op)
      btt_pkg::OP_PROBE: begin
        for (int w = 0; w < NWAY; w++) begin
          if (tbl_meta[b][w].valid && tbl_meta[b][w].tag == r.key[63:48]) begin
            o.hit = 1'b1;
            o.entry_bound = tbl_meta[b][w].bound;
            o.entry_depth = tbl_meta[b][w].depth;
            o.entry_score = tbl_pay[b][w].score_ok ? tbl_pay[b][w].score : 16'sd0;
            o.entry_score_valid = tbl_pay[b][w].score_ok;
            o.entry_eval = tbl_pay[b][w].eval_ok ? tbl_pay[b][w].eval : 16'sd0;
            o.entry_eval_valid = tbl_pay[b][w].eval_ok;
            o.entry_move = tbl_pay[b][w].move;
            break;
          end
        end
      end
      btt_pkg::OP_STORE: table_store(r);
      btt_pkg::OP_EVAL: table_store_eval(r);
      default: table_clear();
    endcase
    o.fill_permille = 10'((occupied * 1000) / (NBKT * NWAY));
    return o;
  endfunction

  function automatic btt_pkg::req_t make_word(logic [1:0] op, logic [63:0] key,
                                              logic [7:0] depth,
                                              logic signed [15:0] score, logic sp,
                                              logic signed [15:0] ev, logic ep,
                                              logic [1:0] bound, logic [14:0] mv);
    btt_pkg::req_t r;
    r.op = op;
    r.key = key;
    r.depth = depth;
    r.score = score;
    r.score_present = sp;
    r.eval_score = ev;
    r.eval_present = ep;
    r.bound_kind = bound;
    r.move_code = mv;
    return r;
  endfunction

  // crowded buckets and a small pool of tags, so ways collide and get evicted
  function automatic btt_pkg::req_t random_word();
    btt_pkg::req_t r;
    int pick;
    r = btt_pkg::req_t'({$urandom, $urandom, $urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 40) r.op = btt_pkg::OP_PROBE;
    else if (pick < 80) r.op = btt_pkg::OP_STORE;
    else if (pick < 99) r.op = btt_pkg::OP_EVAL;
    else r.op = btt_pkg::OP_CLEAR;
    if ($urandom_range(0, 99) < 88) begin
      r.key[63:48] = 16'h5A00 ^ 16'($urandom_range(0, 6));
      r.key[11:0] = 12'($urandom_range(0, 3)) ^ (($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000);
    end
    if ($urandom_range(0, 9) < 3) r.move_code = '0;
    if ($urandom_range(0, 9) < 2) r.depth = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
    return r;
  endfunction

  task automatic report_mismatch(string what, btt_pkg::rsp_t got, btt_pkg::rsp_t want);
    mismatches++;
    $display("mismatch %s at cycle %0d: got %h expected %h", what, cycles, got, want);
  endtask

  // sender
  task automatic send_word(btt_pkg::req_t r, bit typed, btt_pkg::rsp_t typed_result);
    btt_pkg::rsp_t predicted;
    req.valid <= 1'b1;
    req.data <= r;
    do @(posedge clk); while (!(req.valid && req.ready));
    predicted = table_access(r);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic idle_cycles(int n);
    req.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // receiver stall pattern and result check
  int stall_left = 0;
  int run_left = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word", rsp.data, '0);
        end else begin
          btt_pkg::rsp_t want;
          want = pending_results.pop_front();
          if (rsp.data.hit !== want.hit) report_mismatch("hit", rsp.data, want);
          if (rsp.data.entry_bound !== want.entry_bound)
            report_mismatch("entry_bound", rsp.data, want);
          if (rsp.data.entry_depth !== want.entry_depth)
            report_mismatch("entry_depth", rsp.data, want);
          if (rsp.data.entry_score !== want.entry_score)
            report_mismatch("entry_score", rsp.data, want);
          if (rsp.data.entry_score_valid !== want.entry_score_valid)
            report_mismatch("entry_score_valid", rsp.data, want);
          if (rsp.data.entry_eval !== want.entry_eval)
            report_mismatch("entry_eval", rsp.data, want);
          if (rsp.data.entry_eval_valid !== want.entry_eval_valid)
            report_mismatch("entry_eval_valid", rsp.data, want);
          if (rsp.data.entry_move !== want.entry_move)
            report_mismatch("entry_move", rsp.data, want);
          if (rsp.data.fill_permille !== want.fill_permille)
            report_mismatch("fill_permille", rsp.data, want);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rsp.ready <= 1'b0;
      end else if (run_left > 0) begin
        run_left <= run_left - 1;
        rsp.ready <= 1'b1;
      end else begin
        stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        run_left <= $urandom_range(1, 30);
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    btt_pkg::rsp_t none;
    btt_pkg::rsp_t want;
    btt_pkg::req_t r;
    int burst;
    none = '0;
    req.valid = 1'b0;
    req.data = '0;
    table_clear();

    // directed table
    rows.push_back('{make_word(btt_pkg::OP_PROBE, 64'h0, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});
    rows.push_back('{make_word(btt_pkg::OP_PROBE, '1, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});
    rows.push_back('{make_word(btt_pkg::OP_STORE, '1, 8'd255, 16'sh7FFF, 1, 16'sh8000, 1,
                               btt_pkg::BOUND_EXACT, 15'h7FFF), 1'b1, none});
    want = '0;
    want.hit = 1'b1;
    want.entry_bound = btt_pkg::BOUND_EXACT;
    want.entry_depth = 8'd255;
    want.entry_score = 16'sd32000;
    want.entry_score_valid = 1'b1;
    want.entry_eval = -16'sd32000;
    want.entry_eval_valid = 1'b1;
    want.entry_move = 15'h7FFF;
    rows.push_back('{make_word(btt_pkg::OP_PROBE, '1, 0, 0, 0, 0, 0, 0, 0), 1'b1, want});
    // same key shallower: eval updated, deeper score kept
    rows.push_back('{make_word(btt_pkg::OP_STORE, '1, 8'd3, 16'sd5, 1, 16'sd77, 1, 2'd1,
                               15'd9), 1'b0, none});
    rows.push_back('{make_word(btt_pkg::OP_PROBE, '1, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
    // fill one bucket, then force eval and store replacements in it
    rows.push_back('{make_word(btt_pkg::OP_STORE, 64'h0001_0000_0000_0010, 8'd0, 16'sd0, 0,
                               16'sd1, 0, btt_pkg::BOUND_EVAL, 15'd0), 1'b0, none});
    rows.push_back('{make_word(btt_pkg::OP_STORE, 64'h0002_0000_0000_0010, 8'd10, -16'sd100,
                               1, 0, 0, 2'd2, 15'd5), 1'b0, none});
    rows.push_back('{make_word(btt_pkg::OP_STORE, 64'h0003_0000_0000_0010, 8'd20, 16'sd100,
                               1, 0, 0, 2'd1, 15'd0), 1'b0, none});
    rows.push_back('{make_word(btt_pkg::OP_EVAL, 64'h0004_0000_0000_0010, 0, 0, 0,
                               16'sh8000, 0, 0, 0), 1'b0, none});
    rows.push_back('{make_word(btt_pkg::OP_EVAL, 64'h0005_0000_0000_0010, 0, 0, 0, 16'sd12,
                               1, 0, 0), 1'b0, none});
    rows.push_back('{make_word(btt_pkg::OP_STORE, 64'h0006_0000_0000_0010, 8'd1, 16'sd1, 1,
                               0, 0, 2'd1, 15'd1), 1'b0, none});
    rows.push_back('{make_word(btt_pkg::OP_STORE, 64'h0007_0000_0000_0010, 8'd15, 16'sd2, 1,
                               16'sd3, 1, btt_pkg::BOUND_EXACT, 15'd2), 1'b0, none});
    for (int k = 1; k <= 7; k++)
      rows.push_back('{make_word(btt_pkg::OP_PROBE, {16'(k), 48'h10}, 0, 0, 0, 0, 0, 0, 0),
                       1'b0, none});
    rows.push_back('{make_word(btt_pkg::OP_CLEAR, 64'h0, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});
    rows.push_back('{make_word(btt_pkg::OP_PROBE, '1, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      send_word(rows[i].word, rows[i].typed, rows[i].result);
      if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 4));
    end

    burst = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) begin
        idle_cycles(1);
        wait (pending_results.size() == 0);
        @(posedge clk);
      end
      r = random_word();
      send_word(r, 1'b0, none);
      if (burst > 0) begin
        burst--;
      end else begin
        burst = $urandom_range(0, 20);
        idle_cycles($urandom_range(1, 12));
      end
    end
    req.valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
src/btt_pkg.sv
src/btt_if.sv
src/btt_front.sv
src/btt_back.sv
src/bucketed_transposition_table_top.sv
test/bucketed_transposition_table_top_tb.sv
